// ----- rtl/core/whca_pkg.sv -----
// Shared types and constants for the weighted hit cluster accumulator.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package whca_pkg;

  localparam int unsigned MAX_HITS_DEF = 64;   // default MAX_HITS, the cap on the hit limit
  localparam int unsigned ACC_CAP      = 64;   // hits the accumulators can hold

  localparam int unsigned CNT_W     = 7;       // hit count and limit
  localparam int unsigned VAL_W     = 16;      // positions, time, ToT, means
  localparam int unsigned IDX_W     = 8;       // bar index
  localparam int unsigned TOT_SUM_W = 22;      // sum of up to 64 ToT values
  localparam int unsigned WSUM_W    = 39;      // ToT-weighted signed sums
  localparam int unsigned NUM_W     = 40;      // rounded dividend
  localparam int unsigned Q_W       = 16;      // quotient bits, one per step

  localparam logic [CNT_W-1:0] MAX_ELEM_RESET = 7'd16;

  // Cluster state as seen by the mean computation
  typedef struct packed {
    logic                        accepted;
    logic [CNT_W-1:0]            hit_count;
    logic [TOT_SUM_W-1:0]        tot_sum;
    logic signed [WSUM_W-1:0]    bar_sum;
    logic signed [WSUM_W-1:0]    hit_sum;
    logic signed [WSUM_W-1:0]    time_sum;
    logic [IDX_W-1:0]            largest_index;
  } acc_status_t;

endpackage

// ----- rtl/core/whca_acc.sv -----
// Cluster accumulator: hit count, ToT sum, largest hit and three weighted sums.
// The weighted sums grow by a bit-serial multiply over the ToT bits. Uses whca_pkg.
`timescale 1ns / 1ps

module whca_acc #(
  parameter int unsigned MAX_HITS = whca_pkg::MAX_HITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                opcode_i,
  input  logic signed [whca_pkg::VAL_W-1:0]   bar_i,
  input  logic signed [whca_pkg::VAL_W-1:0]   hit_i,
  input  logic signed [whca_pkg::VAL_W-1:0]   time_i,
  input  logic [whca_pkg::VAL_W-1:0]          tot_i,
  input  logic [whca_pkg::IDX_W-1:0]          idx_i,
  input  logic [whca_pkg::CNT_W-1:0]          max_elements_i,
  output logic                                done_o,
  output whca_pkg::acc_status_t               status_o
);
  import whca_pkg::*;

  localparam int unsigned CAP = (MAX_HITS < ACC_CAP) ? MAX_HITS : ACC_CAP;
  localparam logic [CNT_W-1:0] CAP_W = CNT_W'(CAP);
  localparam int unsigned STEP_W = $clog2(VAL_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VAL_W - 1);

  logic [CNT_W-1:0]         limit;
  logic                     clear;
  logic                     accept;
  logic [CNT_W-1:0]         base_count;
  logic [TOT_SUM_W-1:0]     base_tot_sum;

  logic                     busy_q;
  logic                     done_q;
  logic [STEP_W-1:0]        step_q;
  logic                     accepted_q;
  logic [CNT_W-1:0]         hit_count_q;
  logic [TOT_SUM_W-1:0]     tot_sum_q;
  logic signed [WSUM_W-1:0] bar_sum_q, hit_sum_q, time_sum_q;
  logic [VAL_W-1:0]         largest_tot_q;
  logic [IDX_W-1:0]         largest_index_q;

  logic [VAL_W-1:0]         tot_sr_q;
  logic signed [WSUM_W-1:0] mc_bar_q, mc_hit_q, mc_time_q;

  assign limit        = (max_elements_i < CAP_W) ? max_elements_i : CAP_W;
  assign clear        = (opcode_i == 1'b0);
  assign accept       = clear || (hit_count_q < limit);
  assign base_count   = clear ? '0 : hit_count_q;
  assign base_tot_sum = clear ? '0 : tot_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b0;
      done_q          <= 1'b0;
      step_q          <= '0;
      accepted_q      <= 1'b0;
      hit_count_q     <= '0;
      tot_sum_q       <= '0;
      bar_sum_q       <= '0;
      hit_sum_q       <= '0;
      time_sum_q      <= '0;
      largest_tot_q   <= '0;
      largest_index_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q     <= 1'b1;
        step_q     <= '0;
        accepted_q <= accept;
        if (clear) begin
          bar_sum_q  <= '0;
          hit_sum_q  <= '0;
          time_sum_q <= '0;
        end
        if (accept) begin
          hit_count_q <= base_count + CNT_W'(1);
          tot_sum_q   <= base_tot_sum + TOT_SUM_W'(tot_i);
          if ((base_count == '0) || (tot_i > largest_tot_q)) begin
            largest_tot_q   <= tot_i;
            largest_index_q <= idx_i;
          end
        end
      end else if (busy_q) begin
        // one ToT bit per cycle: add the shifted multiplicand where it is set
        if (tot_sr_q[0]) begin
          bar_sum_q  <= bar_sum_q + mc_bar_q;
          hit_sum_q  <= hit_sum_q + mc_hit_q;
          time_sum_q <= time_sum_q + mc_time_q;
        end
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // multiplier operands, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      tot_sr_q  <= accept ? tot_i : '0;
      mc_bar_q  <= WSUM_W'(bar_i);
      mc_hit_q  <= WSUM_W'(hit_i);
      mc_time_q <= WSUM_W'(time_i);
    end else if (busy_q) begin
      tot_sr_q  <= tot_sr_q >> 1;
      mc_bar_q  <= mc_bar_q <<< 1;
      mc_hit_q  <= mc_hit_q <<< 1;
      mc_time_q <= mc_time_q <<< 1;
    end
  end

  assign done_o                 = done_q;
  assign status_o.accepted      = accepted_q;
  assign status_o.hit_count     = hit_count_q;
  assign status_o.tot_sum       = tot_sum_q;
  assign status_o.bar_sum       = bar_sum_q;
  assign status_o.hit_sum       = hit_sum_q;
  assign status_o.time_sum      = time_sum_q;
  assign status_o.largest_index = largest_index_q;

endmodule

// ----- rtl/core/whca_div.sv -----
// Serial restoring divider, one quotient bit per cycle, 16-bit quotient.
// Dividend must be below divisor times 2^16. Uses whca_pkg.
`timescale 1ns / 1ps

module whca_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [whca_pkg::NUM_W-1:0]        num_i,
  input  logic [whca_pkg::TOT_SUM_W-1:0]    den_i,
  output logic                              done_o,
  output logic [whca_pkg::Q_W-1:0]          quot_o
);
  import whca_pkg::*;

  localparam int unsigned STEP_W = $clog2(Q_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);

  logic                   busy_q;
  logic                   done_q;
  logic [STEP_W-1:0]      step_q;
  logic [TOT_SUM_W-1:0]   rem_q;
  logic [TOT_SUM_W-1:0]   den_q;
  logic [Q_W-1:0]         quo_q;

  logic [TOT_SUM_W:0]     trial;
  logic [TOT_SUM_W:0]     diff;
  logic                   ge;

  assign trial = {rem_q, quo_q[Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // upper dividend part is already below the divisor
      rem_q <= num_i[TOT_SUM_W+Q_W-1:Q_W];
      quo_q <= num_i[Q_W-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[TOT_SUM_W-1:0] : trial[TOT_SUM_W-1:0];
      quo_q <= {quo_q[Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- rtl/core/weighted_hit_cluster_accumulator_core.sv -----
// Top level of the weighted hit cluster accumulator core.
// Instantiates whca_acc and whca_div; uses whca_pkg.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): one bar hit per request. tuser carries the
//   opcode: 0 opens a new cluster with this hit, 1 adds the hit to the
//   current cluster. An add beyond the hit limit is rejected and leaves the
//   cluster as it was.
//   Output stream (m_axis_*): one result per request with the multiplicity,
//   the ToT-weighted means of bar position, hit position and time, the plain
//   mean ToT and the bar index of the largest hit. tuser flags a zero total
//   ToT, in which case the three weighted means read zero.
//   Configuration: cfg_we_i writes cfg_wdata_i into the hit limit
//   (max_elements); write it only while no request is in flight.
//   Sequence: the accept cycle, the bit-serial multiply over the ToT bits
//   (16 steps, then a done pulse), four passes through the one shared
//   serial divider (three weighted means, then mean ToT) and the output load.
//   The result shows on m_axis after the last division, when tready returns
//   as well.
//   Stall: the result waits in the output register. The next request is
//   accepted meanwhile; its result holds in the core until the register frees.
//   Reset: clears the cluster and sets the hit limit to 16.
module weighted_hit_cluster_accumulator_core #(
  parameter int unsigned MAX_HITS = whca_pkg::MAX_HITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] bar_position, [31:16] hit_position, [47:32] hit_time,
  // [63:48] tot, [71:64] bar_index
  input  logic [71:0]                      s_axis_tdata,
  // [0] opcode
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] accepted, [7:1] multiplicity, [23:8] mean_bar_position,
  // [39:24] mean_hit_position, [55:40] mean_time, [71:56] mean_tot,
  // [79:72] max_bar_index
  output logic [79:0]                      m_axis_tdata,
  // [0] zero_weight
  output logic [0:0]                       m_axis_tuser,
  input  logic                             cfg_we_i,
  input  logic [whca_pkg::CNT_W-1:0]       cfg_wdata_i
);
  import whca_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MAC    = 5'b00010,
    S_SETUP  = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    DIV_BAR  = 2'd0,
    DIV_HIT  = 2'd1,
    DIV_TIME = 2'd2,
    DIV_TOT  = 2'd3
  } div_sel_e;

  state_e               state_q;
  div_sel_e             sel_q;
  logic [CNT_W-1:0]     max_elements_q;
  logic                 s_fire;
  logic                 load_out;

  acc_status_t          status;
  logic                 acc_done;

  // division operands
  logic signed [WSUM_W-1:0] wsum;
  logic [WSUM_W-1:0]        wsum_u;
  logic                     neg;
  logic [WSUM_W-1:0]        mag;
  logic [NUM_W-1:0]         num;
  logic [TOT_SUM_W-1:0]     den;
  logic                     zero_div;
  logic                     div_start;
  logic                     div_done;
  logic [Q_W-1:0]           quot;
  logic [Q_W-1:0]           quot_signed;
  logic [Q_W-1:0]           result;
  logic                     neg_q;
  logic                     zero_q;

  logic [VAL_W-1:0]     mean_bar_q, mean_hit_q, mean_time_q, mean_tot_q;

  logic                 m_valid_q;
  logic [79:0]          m_data_q;
  logic [0:0]           m_user_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == S_FINISH) && (!m_valid_q || m_axis_tready);
  assign div_start     = (state_q == S_SETUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_elements_q <= MAX_ELEM_RESET;
    end else if (cfg_we_i) begin
      max_elements_q <= cfg_wdata_i;
    end
  end

  whca_acc #(
    .MAX_HITS (MAX_HITS)
  ) u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (s_fire),
    .opcode_i       (s_axis_tuser[0]),
    .bar_i          ($signed(s_axis_tdata[15:0])),
    .hit_i          ($signed(s_axis_tdata[31:16])),
    .time_i         ($signed(s_axis_tdata[47:32])),
    .tot_i          (s_axis_tdata[63:48]),
    .idx_i          (s_axis_tdata[71:64]),
    .max_elements_i (max_elements_q),
    .done_o         (acc_done),
    .status_o       (status)
  );

  // Pick the dividend for the current mean and round it to nearest:
  // weighted means divide |sum| + tot_sum/2 by tot_sum and restore the sign,
  // mean ToT divides tot_sum + count/2 by the count.
  always_comb begin
    case (sel_q)
      DIV_BAR:  wsum = status.bar_sum;
      DIV_HIT:  wsum = status.hit_sum;
      DIV_TIME: wsum = status.time_sum;
      default:  wsum = '0;
    endcase
    wsum_u = wsum;
    mag    = wsum_u[WSUM_W-1] ? (~wsum_u + WSUM_W'(1)) : wsum_u;
    if (sel_q == DIV_TOT) begin
      neg      = 1'b0;
      num      = NUM_W'(status.tot_sum) + NUM_W'(status.hit_count >> 1);
      den      = TOT_SUM_W'(status.hit_count);
      zero_div = (status.hit_count == '0);
    end else begin
      neg      = wsum_u[WSUM_W-1];
      num      = NUM_W'(mag) + NUM_W'(status.tot_sum >> 1);
      den      = status.tot_sum;
      zero_div = (status.tot_sum == '0);
    end
  end

  whca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign quot_signed = neg_q ? (~quot + Q_W'(1)) : quot;
  assign result      = zero_q ? '0 : quot_signed;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= DIV_BAR;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_fire) state_q <= S_MAC;
        end
        S_MAC: begin
          if (acc_done) begin
            sel_q   <= DIV_BAR;
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (sel_q == DIV_TOT) begin
              state_q <= S_FINISH;
            end else begin
              sel_q   <= div_sel_e'(sel_q + 2'd1);
              state_q <= S_SETUP;
            end
          end
        end
        S_FINISH: begin
          if (load_out) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // latch sign and zero case with the division start, store each mean
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      neg_q  <= neg;
      zero_q <= zero_div;
    end
    if ((state_q == S_DIV) && div_done) begin
      case (sel_q)
        DIV_BAR:  mean_bar_q  <= result;
        DIV_HIT:  mean_hit_q  <= result;
        DIV_TIME: mean_time_q <= result;
        default:  mean_tot_q  <= result;
      endcase
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {status.largest_index, mean_tot_q, mean_time_q, mean_hit_q,
                   mean_bar_q, status.hit_count, status.accepted};
      m_user_q <= (status.tot_sum == '0);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ----- tb/tb_weighted_hit_cluster_accumulator_core.sv -----
// Self-checking testbench for weighted_hit_cluster_accumulator_core.
// Drives hit requests and hit-limit writes, predicts every cluster report and
// checks it field by field; depends on whca_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_weighted_hit_cluster_accumulator_core;

  import whca_pkg::*;

  localparam int unsigned HIT_CAP     = (MAX_HITS_DEF < ACC_CAP) ? MAX_HITS_DEF : ACC_CAP;
  localparam int          SETTLE      = 8;      // idle cycles before a limit write
  localparam int          QUIET_LIMIT = 4000;   // cycles with nothing accepted
  localparam int          TAIL_CYCLES = 120;    // one latency and some margin

  typedef enum logic [0:0] {OP_START = 1'b0, OP_ADD = 1'b1} hit_op_e;
  typedef enum logic [1:0] {STIM_HIT, STIM_CFG, STIM_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e         kind;
    hit_op_e            op;
    logic signed [15:0] bar;
    logic signed [15:0] pos;
    logic signed [15:0] tm;
    logic [15:0]        tot;
    logic [7:0]         idx;
    logic [CNT_W-1:0]   limit;
  } stim_t;

  typedef struct packed {
    logic             accepted;
    logic [CNT_W-1:0] mult;
    logic [15:0]      mbar;
    logic [15:0]      mpos;
    logic [15:0]      mtime;
    logic [15:0]      mtot;
    logic [7:0]       top;
    logic             zero_w;
  } cluster_report_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [71:0]      s_axis_tdata  = '0;
  logic [0:0]       s_axis_tuser  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [79:0]      m_axis_tdata;
  logic [0:0]       m_axis_tuser;
  logic             cfg_we_i      = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i   = '0;

  stim_t           hit_requests[$];
  cluster_report_t expected_reports[$];
  int              mismatches   = 0;
  int              gap_left     = 0;
  int              settle_left  = SETTLE;
  int              stall_left   = 0;
  int              quiet_cycles = 0;
  bit              src_steady   = 1'b0;
  bit              sink_steady  = 1'b0;

  // Predicted cluster state and hit limit
  logic [CNT_W-1:0]         hit_limit;
  logic [CNT_W-1:0]         n_hits;
  logic [TOT_SUM_W-1:0]     tot_acc;
  logic signed [WSUM_W-1:0] bar_acc;
  logic signed [WSUM_W-1:0] pos_acc;
  logic signed [WSUM_W-1:0] time_acc;
  logic [15:0]              top_tot;
  logic [7:0]               top_idx;

  always #1 clk_i = ~clk_i;

  weighted_hit_cluster_accumulator_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Weighted mean: round to nearest, ties away from zero
  function automatic logic [15:0] round_mean(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return 16'((num < 0) ? -q : q);
  endfunction

  // Fold one hit into the predicted cluster and return the report it causes
  function automatic cluster_report_t fold_hit(input hit_op_e op,
                                               input logic signed [15:0] bar, pos, tm,
                                               input logic [15:0] tot,
                                               input logic [7:0] idx);
    cluster_report_t rep;
    logic [CNT_W-1:0] lim;
    logic             take;
    lim = (hit_limit > HIT_CAP) ? CNT_W'(HIT_CAP) : hit_limit;
    if (op == OP_START) begin
      n_hits   = '0;
      tot_acc  = '0;
      bar_acc  = '0;
      pos_acc  = '0;
      time_acc = '0;
      top_tot  = '0;
      top_idx  = '0;
      take     = 1'b1;
    end else begin
      take = (n_hits < lim);
    end
    if (take) begin
      // first hit of a cluster always becomes the largest, even at zero ToT
      if (n_hits == 0 || tot > top_tot) begin
        top_tot = tot;
        top_idx = idx;
      end
      n_hits   = n_hits + 1'b1;
      tot_acc  = tot_acc + tot;
      bar_acc  = bar_acc + WSUM_W'(longint'(bar) * longint'(tot));
      pos_acc  = pos_acc + WSUM_W'(longint'(pos) * longint'(tot));
      time_acc = time_acc + WSUM_W'(longint'(tm) * longint'(tot));
    end
    rep.accepted = take;
    rep.mult     = n_hits;
    rep.zero_w   = (tot_acc == 0);
    rep.mbar     = rep.zero_w ? 16'd0 : round_mean(bar_acc, tot_acc);
    rep.mpos     = rep.zero_w ? 16'd0 : round_mean(pos_acc, tot_acc);
    rep.mtime    = rep.zero_w ? 16'd0 : round_mean(time_acc, tot_acc);
    rep.mtot     = (n_hits == 0) ? 16'd0 : 16'((tot_acc + n_hits / 2) / n_hits);
    rep.top      = top_idx;
    return rep;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
      mismatches++;
    end
  endtask

  // Sender gaps: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // Receiver stalls: mostly none or short, now and then long
  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (sink_steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic push_hit(input hit_op_e op, input logic [15:0] bar, pos, tm, tot,
                          input logic [7:0] idx);
    stim_t s;
    s.kind  = STIM_HIT;
    s.op    = op;
    s.bar   = bar;
    s.pos   = pos;
    s.tm    = tm;
    s.tot   = tot;
    s.idx   = idx;
    s.limit = '0;
    hit_requests = {hit_requests, s};
  endtask

  task automatic push_ctrl(input stim_kind_e kind, input logic [CNT_W-1:0] limit);
    stim_t s;
    s.kind  = kind;
    s.op    = OP_START;
    s.bar   = '0;
    s.pos   = '0;
    s.tm    = '0;
    s.tot   = '0;
    s.idx   = '0;
    s.limit = limit;
    hit_requests = {hit_requests, s};
  endtask

  function automatic logic [15:0] rnd_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 16'h8000;
    if (r < 16) return 16'h7FFF;
    if (r < 20) return 16'h0000;
    if (r < 24) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rnd_tot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 18) return 16'hFFFF;
    if (r < 32) return 16'($urandom_range(1, 4));
    return 16'($urandom);
  endfunction

  task automatic push_rand(input hit_op_e op);
    push_hit(op, rnd_coord(), rnd_coord(), rnd_coord(), rnd_tot(), 8'($urandom));
  endtask

  // One limit setting followed by clusters of random length and content
  task automatic random_phase(input logic [CNT_W-1:0] lim_cfg, input int n_items);
    int eff;
    int count;
    int len;
    eff   = (lim_cfg > HIT_CAP) ? HIT_CAP : lim_cfg;
    count = 0;
    push_ctrl(STIM_CFG, lim_cfg);
    while (count < n_items) begin
      // leave out the start now and then so adds pile onto the old cluster
      if ($urandom_range(0, 99) < 85) begin
        push_rand(OP_START);
        count++;
      end
      if ($urandom_range(0, 3) == 0) len = $urandom_range(0, eff + 3);
      else len = $urandom_range(0, ((eff < 6) ? eff : 6) + 2);
      repeat (len) push_rand(OP_ADD);
      count += len;
      if ($urandom_range(0, 39) == 0) push_ctrl(STIM_DRAIN, '0);
    end
  endtask

  task automatic build_stimulus();
    logic [CNT_W-1:0] lims[12];
    // add on the empty cluster right after reset acts as its first hit
    push_hit(OP_ADD, 16'd7, 16'd7, 16'd7, 16'd0, 8'd200);
    push_hit(OP_ADD, 16'd3, 16'd3, 16'd3, 16'd0, 8'd201);
    // zero total weight
    push_hit(OP_START, 16'h8000, 16'h7FFF, 16'h1234, 16'd0, 8'd9);
    push_hit(OP_ADD, 16'h7FFF, 16'h8000, 16'h4321, 16'd0, 8'd10);
    // field extremes; equal ToT keeps the earlier hit
    push_hit(OP_START, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 8'd255);
    push_hit(OP_ADD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 8'd0);
    push_hit(OP_ADD, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd0, 8'd17);
    // rounding ties of the weighted means, then a larger hit takes over
    push_hit(OP_START, 16'hFFFF, 16'd1, 16'd0, 16'd1, 8'd1);
    push_hit(OP_ADD, 16'hFFFE, 16'd2, 16'hFFFF, 16'd1, 8'd2);
    push_hit(OP_ADD, 16'd5, 16'hFFFB, 16'd0, 16'd2, 8'd4);
    // rounding tie of the mean ToT
    push_hit(OP_START, 16'd1, 16'd1, 16'd1, 16'd1, 8'd5);
    push_hit(OP_ADD, 16'd2, 16'd2, 16'd2, 16'd2, 8'd6);
    push_ctrl(STIM_DRAIN, '0);
    // zero limit: starts still go in, every add is rejected
    push_ctrl(STIM_CFG, 7'd0);
    push_hit(OP_ADD, 16'd1, 16'd1, 16'd1, 16'd9, 8'd11);
    push_hit(OP_START, 16'd4, 16'hFFFC, 16'd8, 16'd3, 8'd12);
    push_hit(OP_ADD, 16'd9, 16'd9, 16'd9, 16'd50, 8'd13);
    // limit of one
    push_ctrl(STIM_CFG, 7'd1);
    push_hit(OP_START, 16'd100, 16'd200, 16'd300, 16'd7, 8'd14);
    push_hit(OP_ADD, 16'd1, 16'd2, 16'd3, 16'd70, 8'd15);
    // register beyond the accumulator capacity, then exactly at it:
    // fill the cluster to the brim with extreme values and overrun it
    push_ctrl(STIM_CFG, 7'd127);
    push_hit(OP_START, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 8'd0);
    for (int i = 0; i < 66; i++) push_hit(OP_ADD, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 8'(i));
    push_ctrl(STIM_CFG, 7'd64);
    push_hit(OP_START, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 8'd77);
    for (int i = 0; i < 65; i++) push_hit(OP_ADD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 8'(i));
    push_ctrl(STIM_DRAIN, '0);
    lims = '{7'd2, 7'd16, 7'd64, 7'd127, 7'd1, 7'd0, 7'd37, CNT_W'($urandom_range(1, 64)),
             CNT_W'($urandom_range(0, 127)), 7'd64, 7'd5, 7'd100};
    foreach (lims[i]) random_phase(lims[i], 150);
  endtask

  // ------------------------------------------------------------------ driver

  always @(posedge clk_i or negedge rst_ni) begin : source_p
    logic  go_valid;
    logic  go_we;
    stim_t head;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      cfg_we_i      <= 1'b0;
      cfg_wdata_i   <= '0;
      gap_left    = 0;
      settle_left = SETTLE;
    end else begin
      go_valid = s_axis_tvalid;
      go_we    = 1'b0;
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the request until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        go_valid = 1'b0;
      end else if (hit_requests.size() == 0) begin
        go_valid = 1'b0;
      end else if (hit_requests[0].kind == STIM_HIT) begin
        head = hit_requests.pop_front();
        s_axis_tdata <= {head.idx, head.tot, head.tm, head.pos, head.bar};
        s_axis_tuser <= head.op;
        go_valid = 1'b1;
        gap_left = pick_gap();
        if ($urandom_range(0, 149) == 0) src_steady = ~src_steady;
      end else begin
        // drain point: wait for every report and settle, then write the limit if the entry carries one
        go_valid = 1'b0;
        if (s_axis_tvalid || expected_reports.size() != 0) begin
          settle_left = SETTLE;
        end else if (settle_left > 0) begin
          settle_left--;
        end else begin
          head = hit_requests.pop_front();
          if (head.kind == STIM_CFG) begin
            go_we = 1'b1;
            cfg_wdata_i <= head.limit;
          end
          settle_left = SETTLE;
        end
      end
      s_axis_tvalid <= go_valid;
      cfg_we_i      <= go_we;
    end
  end

  // --------------------------------------------------------------- predictor

  always @(posedge clk_i or negedge rst_ni) begin : predict_p
    if (!rst_ni) begin
      hit_limit = MAX_ELEM_RESET;
      n_hits    = '0;
      tot_acc   = '0;
      bar_acc   = '0;
      pos_acc   = '0;
      time_acc  = '0;
      top_tot   = '0;
      top_idx   = '0;
    end else begin
      if (cfg_we_i) hit_limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_reports = {expected_reports,
                            fold_hit(hit_op_e'(s_axis_tuser[0]), s_axis_tdata[15:0],
                                     s_axis_tdata[31:16], s_axis_tdata[47:32],
                                     s_axis_tdata[63:48], s_axis_tdata[71:64])};
      end
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk_i or negedge rst_ni) begin : sink_p
    cluster_report_t want;
    cluster_report_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.accepted = m_axis_tdata[0];
        got.mult     = m_axis_tdata[7:1];
        got.mbar     = m_axis_tdata[23:8];
        got.mpos     = m_axis_tdata[39:24];
        got.mtime    = m_axis_tdata[55:40];
        got.mtot     = m_axis_tdata[71:56];
        got.top      = m_axis_tdata[79:72];
        got.zero_w   = m_axis_tuser[0];
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %0h", $time, got);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("accepted", want.accepted, got.accepted);
          check_field("multiplicity", want.mult, got.mult);
          check_field("mean_bar_position", want.mbar, got.mbar);
          check_field("mean_hit_position", want.mpos, got.mpos);
          check_field("mean_time", want.mtime, got.mtime);
          check_field("mean_tot", want.mtot, got.mtot);
          check_field("max_bar_index", want.top, got.top);
          check_field("zero_weight", want.zero_w, got.zero_w);
        end
        stall_left = pick_stall();
        if ($urandom_range(0, 149) == 0) sink_steady = ~sink_steady;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!sink_steady && $urandom_range(0, 63) == 0) begin
        // drop ready at an arbitrary point of the block's work
        stall_left = pick_stall();
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk_i) begin : watchdog_p
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("** weighted_hit_cluster_accumulator_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------- reset and end

  initial begin
    build_stimulus();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (hit_requests.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d reports never arrived, first expected %0h", $time,
               expected_reports.size(), expected_reports[0]);
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** weighted_hit_cluster_accumulator_core: PASSED **");
    end else begin
      $display("** weighted_hit_cluster_accumulator_core: FAILED **");
    end
    $finish;
  end

endmodule
